FILE: src/gtsb_pkg.sv
`default_nettype none

package gtsb_pkg;

  // byte arithmetic constants
  localparam logic [7:0] Full    = 8'd255;
  localparam logic [6:0] RndBias = 7'd127;

  typedef enum logic [1:0] {
    ModeFill   = 2'd0,
    ModeAlpha8 = 2'd1,
    ModeLcd    = 2'd2,
    ModeBgra   = 2'd3
  } mode_e;

  // input beat
  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] draw_color;
    logic [31:0] atlas_texel;
    logic [31:0] dest_pixel;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_alpha;
  } out_beat_t;

  // shaded premultiplied source, byte 0 blue .. byte 3 alpha
  typedef struct packed {
    mode_e           mode;
    logic [3:0][7:0] src;
    logic [3:0][7:0] dest;
  } shaded_t;

  // exact floor(x / 255) for x up to 2^17 - 512, covers every blend sum
  function automatic logic [8:0] div255(input logic [16:0] x);
    logic [17:0] t;
    logic [8:0]  q;
    logic [16:0] r;
    t = {1'b0, x} + {9'b0, x[16:8]};
    q = t[16:8];
    r = x - ({q, 8'b0} - {8'b0, q});
    if (r >= {9'b0, Full}) begin
      q = q + 9'd1;
    end
    return q;
  endfunction

  // (a * b + 127) / 255
  function automatic logic [7:0] mul8(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] p;
    logic [16:0] s;
    logic [8:0]  q;
    p = a * b;
    s = {1'b0, p} + {10'b0, RndBias};
    q = div255(s);
    return q[7:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/gtsb_shade.sv
`default_nettype none

module gtsb_shade (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire gtsb_pkg::in_beat_t in_data_i,
  output logic                   in_stall_o,
  output logic                   sh_valid_o,
  output gtsb_pkg::shaded_t      sh_data_o,
  input  wire logic              sh_ready_i
);

  // first product stage
  typedef struct packed {
    gtsb_pkg::mode_e mode;
    logic [3:0][7:0] color;
    logic [3:0][7:0] texel;
    logic [3:0][7:0] dest;
    logic [2:0][7:0] prod;
    logic [7:0]      alpha;
  } prod_t;

  prod_t             s1_d, s1_q;
  logic              v1_q;
  gtsb_pkg::shaded_t s2_d, s2_q;
  logic              v2_q;
  logic              ready1, ready2;
  logic [7:0]        ca, tmax;
  logic [3:0][7:0]   tex_in;

  assign ready2     = !v2_q || sh_ready_i;
  assign ready1     = !v1_q || ready2;
  assign in_stall_o = !ready1;

  assign tex_in = in_data_i.atlas_texel;
  assign ca     = in_data_i.draw_color[31:24];

  // largest rgb coverage
  always_comb begin
    tmax = tex_in[0];
    if (tex_in[1] > tmax) begin
      tmax = tex_in[1];
    end
    if (tex_in[2] > tmax) begin
      tmax = tex_in[2];
    end
  end

  always_comb begin
    s1_d.mode  = gtsb_pkg::mode_e'(in_data_i.cmd);
    s1_d.color = in_data_i.draw_color;
    s1_d.texel = in_data_i.atlas_texel;
    s1_d.dest  = in_data_i.dest_pixel;
    for (int i = 0; i < 3; i++) begin
      if (s1_d.mode == gtsb_pkg::ModeLcd) begin
        s1_d.prod[i] = gtsb_pkg::mul8(s1_d.color[i], ca);
      end else begin
        s1_d.prod[i] = gtsb_pkg::mul8(tex_in[i], ca);
      end
    end
    if (s1_d.mode == gtsb_pkg::ModeLcd) begin
      s1_d.alpha = gtsb_pkg::mul8(ca, tmax);
    end else begin
      s1_d.alpha = gtsb_pkg::mul8(ca, tex_in[3]);
    end
  end

  always_comb begin
    s2_d.mode = s1_q.mode;
    s2_d.dest = s1_q.dest;
    s2_d.src  = s1_q.color;
    unique case (s1_q.mode)
      gtsb_pkg::ModeFill: begin
        s2_d.src = s1_q.color;
      end
      gtsb_pkg::ModeAlpha8: begin
        for (int i = 0; i < 3; i++) begin
          s2_d.src[i] = gtsb_pkg::mul8(s1_q.color[i], s1_q.alpha);
        end
        s2_d.src[3] = s1_q.alpha;
      end
      gtsb_pkg::ModeLcd: begin
        for (int i = 0; i < 3; i++) begin
          s2_d.src[i] = gtsb_pkg::mul8(s1_q.prod[i], s1_q.texel[i]);
        end
        s2_d.src[3] = s1_q.alpha;
      end
      gtsb_pkg::ModeBgra: begin
        for (int i = 0; i < 3; i++) begin
          s2_d.src[i] = s1_q.prod[i];
        end
        s2_d.src[3] = s1_q.alpha;
      end
      default: begin
        s2_d.src = s1_q.color;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= in_valid_i;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && ready1) begin
      s1_q <= s1_d;
    end
    if (v1_q && ready2) begin
      s2_q <= s2_d;
    end
  end

  assign sh_valid_o = v2_q;
  assign sh_data_o  = s2_q;

  // a blocked product stage keeps its beat
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !ready2) |=> (v1_q && $stable(s1_q)))
    else $error("product stage lost its beat while blocked");

  // coverage-shaded colors never exceed their alpha
  a_src_le_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && (s2_q.mode == gtsb_pkg::ModeAlpha8 || s2_q.mode == gtsb_pkg::ModeLcd)) |->
    (s2_q.src[0] <= s2_q.src[3] && s2_q.src[1] <= s2_q.src[3] &&
     s2_q.src[2] <= s2_q.src[3]))
    else $error("shaded channel above shaded alpha");

endmodule

`default_nettype wire

FILE: src/gtsb_blend.sv
`default_nettype none

module gtsb_blend (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               sh_valid_i,
  input  wire gtsb_pkg::shaded_t  sh_data_i,
  output logic                    sh_ready_o,
  output logic                    out_valid_o,
  output gtsb_pkg::out_beat_t     out_data_o,
  input  wire logic               out_stall_i
);

  logic [3:0][16:0]    sum;
  logic [3:0][8:0]     quo;
  logic [3:0][7:0]     res;
  logic [7:0]          inv_a;
  gtsb_pkg::out_beat_t out_d, out_q;
  logic                v3_q;
  logic                load;

  assign sh_ready_o = !v3_q || !out_stall_i;
  assign load       = sh_valid_i && sh_ready_o;
  assign inv_a      = gtsb_pkg::Full - sh_data_i.src[3];

  // s*255 + d*(255-sa) + 127, divided and saturated
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum[i] = 17'(sh_data_i.src[i]) * 17'(gtsb_pkg::Full)
             + 17'(sh_data_i.dest[i]) * 17'(inv_a)
             + 17'(gtsb_pkg::RndBias);
      quo[i] = gtsb_pkg::div255(sum[i]);
      res[i] = (quo[i] > {1'b0, gtsb_pkg::Full}) ? gtsb_pkg::Full : quo[i][7:0];
    end
    out_d.out_blue  = res[0];
    out_d.out_green = res[1];
    out_d.out_red   = res[2];
    out_d.out_alpha = res[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (sh_ready_o) begin
      v3_q <= sh_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = out_q;

  // opaque source replaces the destination
  a_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && sh_data_i.src[3] == gtsb_pkg::Full) |=>
    (out_q.out_blue == $past(sh_data_i.src[0]) &&
     out_q.out_green == $past(sh_data_i.src[1]) &&
     out_q.out_red == $past(sh_data_i.src[2]) &&
     out_q.out_alpha == $past(sh_data_i.src[3])))
    else $error("opaque source did not replace destination");

  // fully transparent black leaves the destination
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && sh_data_i.src == 32'd0) |=>
    (out_q.out_blue == $past(sh_data_i.dest[0]) &&
     out_q.out_green == $past(sh_data_i.dest[1]) &&
     out_q.out_red == $past(sh_data_i.dest[2]) &&
     out_q.out_alpha == $past(sh_data_i.dest[3])))
    else $error("transparent source changed destination");

endmodule

`default_nettype wire

FILE: src/glyph_texel_shade_and_blend.sv
// channel  direction  handshake                   payload
// in       input      in_valid_i / in_stall_o     gtsb_pkg::in_beat_t  (mode, color, texel, dest)
// out      output     out_valid_o / out_stall_i   gtsb_pkg::out_beat_t (blended bgra)
//
// one beat per clock sustained while out_stall_i is low; each beat passes through the
// product stage, the coverage stage and the blend/output register
// each stage has its own valid bit and loads when empty or draining, so
// bubbles close up under a stall and stall_o is low while any stage can move
// reset clears only the valid bits; the data registers are not reset
`default_nettype none

module glyph_texel_shade_and_blend (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire gtsb_pkg::in_beat_t  in_data_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  output gtsb_pkg::out_beat_t      out_data_o,
  input  wire logic                out_stall_i
);

  // shaded source between the shader and the blender
  logic              sh_valid;
  logic              sh_ready;
  gtsb_pkg::shaded_t sh_data;

  // stages one and two: mode-dependent premultiply
  gtsb_shade u_shade (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .sh_valid_o (sh_valid),
    .sh_data_o  (sh_data),
    .sh_ready_i (sh_ready)
  );

  // stage three: source-over with saturation, output register
  gtsb_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sh_valid_i  (sh_valid),
    .sh_data_i   (sh_data),
    .sh_ready_o  (sh_ready),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

  // an idle pipeline never pushes back on the input
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !sh_valid) |-> !in_stall_o)
    else $error("input stalled while downstream empty");

endmodule

`default_nettype wire

FILE: verif/gtsb_pixel_checker.sv
module gtsb_pixel_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  gtsb_pkg::in_beat_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  gtsb_pkg::out_beat_t out_data_i,
  output int                  mismatch_cnt_o,
  output int                  pending_cnt_o,
  output int                  shaded_cnt_o,
  output int                  checked_cnt_o
);

  localparam int unsigned ByteMax   = 255;
  localparam int unsigned RoundBias = 127;
  // keep the log readable on a badly broken block
  localparam int          ReportCap = 200;

  // predicted pixels in order, indexed by a running beat count
  gtsb_pkg::out_beat_t expected_pixels[int];
  int                  head_idx = 0;
  int                  tail_idx = 0;
  int                  errs     = 0;
  int                  shaded   = 0;
  int                  checked  = 0;

  // (a * b + 127) / 255
  function automatic logic [7:0] scale8(input logic [7:0] a, input logic [7:0] b);
    int unsigned p;
    p = (32'(a) * 32'(b) + RoundBias) / ByteMax;
    return p[7:0];
  endfunction

  // source-over of one channel, saturating
  function automatic logic [7:0] over8(input logic [7:0] s, input logic [7:0] d,
                                       input logic [7:0] sa);
    int unsigned v;
    v = (32'(s) * ByteMax + 32'(d) * (ByteMax - 32'(sa)) + RoundBias) / ByteMax;
    return (v > ByteMax) ? 8'hff : v[7:0];
  endfunction

  function automatic gtsb_pkg::out_beat_t shade_over_dest(input gtsb_pkg::in_beat_t beat);
    logic [3:0][7:0]     color;
    logic [3:0][7:0]     texel;
    logic [3:0][7:0]     dest;
    logic [3:0][7:0]     src;
    logic [7:0]          cov;
    logic [7:0]          a;
    gtsb_pkg::out_beat_t res;
    int                  c;
    color = beat.draw_color;
    texel = beat.atlas_texel;
    dest  = beat.dest_pixel;
    src   = '0;
    case (gtsb_pkg::mode_e'(beat.cmd))
      gtsb_pkg::ModeFill: begin
        src = color;
      end
      gtsb_pkg::ModeAlpha8: begin
        a = scale8(color[3], texel[3]);
        for (c = 0; c < 3; c++) src[c] = scale8(color[c], a);
        src[3] = a;
      end
      gtsb_pkg::ModeLcd: begin
        cov = texel[0];
        if (texel[1] > cov) cov = texel[1];
        if (texel[2] > cov) cov = texel[2];
        for (c = 0; c < 3; c++) src[c] = scale8(scale8(color[c], color[3]), texel[c]);
        src[3] = scale8(color[3], cov);
      end
      gtsb_pkg::ModeBgra: begin
        for (c = 0; c < 4; c++) src[c] = scale8(texel[c], color[3]);
      end
    endcase
    res.out_blue  = over8(src[0], dest[0], src[3]);
    res.out_green = over8(src[1], dest[1], src[3]);
    res.out_red   = over8(src[2], dest[2], src[3]);
    res.out_alpha = over8(src[3], dest[3], src[3]);
    return res;
  endfunction

  task automatic check_channel(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      if (errs < ReportCap) $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk_i) begin
    gtsb_pkg::out_beat_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (head_idx == tail_idx) begin
          if (errs < ReportCap) $error("output beat %h with nothing expected", out_data_i);
          errs++;
        end else begin
          want = expected_pixels[head_idx];
          expected_pixels.delete(head_idx);
          head_idx++;
          check_channel("out_blue",  want.out_blue,  out_data_i.out_blue);
          check_channel("out_green", want.out_green, out_data_i.out_green);
          check_channel("out_red",   want.out_red,   out_data_i.out_red);
          check_channel("out_alpha", want.out_alpha, out_data_i.out_alpha);
          checked++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_pixels[tail_idx] = shade_over_dest(in_data_i);
        tail_idx++;
        shaded++;
      end
    end
    mismatch_cnt_o <= errs;
    pending_cnt_o  <= tail_idx - head_idx;
    shaded_cnt_o   <= shaded;
    checked_cnt_o  <= checked;
  end

endmodule

FILE: verif/tb_glyph_texel_shade_and_blend.sv
module tb_glyph_texel_shade_and_blend;

  // receiver hold-off length, forces the pipe to fill and back up
  localparam int HoldOffCycles = 60;
  // cycles with no beat on either channel before giving up
  localparam int QuietLimit    = 500;
  // settle time after the last result
  localparam int DrainCycles   = 8;
  localparam int RandomHead    = 250;
  localparam int SteadyRun     = 150;
  localparam int RandomTail    = 180;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  gtsb_pkg::in_beat_t  in_data_i   = '0;
  logic                in_stall_o;
  logic                out_valid_o;
  gtsb_pkg::out_beat_t out_data_o;
  logic                out_stall_i = 1'b0;

  // stimulus knobs: src idling is read only by the sender, the rest by the receiver
  bit        src_idle_en  = 1'b1;
  bit        sink_idle_en = 1'b1;
  int        hold_req     = 0;

  int        mismatch_cnt;
  int        pending_cnt;
  int        shaded_cnt;
  int        checked_cnt;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  glyph_texel_shade_and_blend u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

  gtsb_pixel_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .in_data_i      (in_data_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_i     (out_data_o),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt),
    .shaded_cnt_o   (shaded_cnt),
    .checked_cnt_o  (checked_cnt)
  );

  // byte biased toward the extremes, where rounding and saturation bite
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // bgra word, either fully random or assembled from biased bytes
  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    int          k;
    if ($urandom_range(3) == 0) return $urandom;
    for (k = 0; k < 4; k++) w[8*k +: 8] = pick_byte();
    return w;
  endfunction

  function automatic gtsb_pkg::in_beat_t make_pixel(input gtsb_pkg::mode_e mode,
                                                    input logic [31:0] color,
                                                    input logic [31:0] texel,
                                                    input logic [31:0] dest);
    gtsb_pkg::in_beat_t b;
    b.cmd         = mode;
    b.draw_color  = color;
    b.atlas_texel = texel;
    b.dest_pixel  = dest;
    return b;
  endfunction

  function automatic gtsb_pkg::in_beat_t random_pixel();
    return make_pixel(gtsb_pkg::mode_e'($urandom_range(3)), pick_word(), pick_word(),
                      pick_word());
  endfunction

  // called and returning at a falling edge; valid stays high between
  // back-to-back beats so it only gets one assignment per step
  task automatic offer_pixel(input gtsb_pkg::in_beat_t beat);
    while (src_idle_en && ($urandom_range(99) < 36)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    // stall seen at the edge is the pre-edge value, so this is the real handshake
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // receiver: random stall, none at all, or one long hold-off on request
  initial begin : sink_drive
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_stall_i <= 1'b1;
        // counted here, while the sender keeps pushing into a full pipe
        repeat (HoldOffCycles) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= sink_idle_en && ($urandom_range(99) < 36);
      end
    end
  end

  // watchdog on cycles where neither channel moves a beat
  initial begin : quiet_watch
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
      if (quiet >= QuietLimit) begin
        $display("timeout: no beat moved for %0d cycles, %0d results outstanding",
                 QuietLimit, pending_cnt);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int n;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // fill: zeros, ones, color above alpha saturating, texel ignored
    offer_pixel(make_pixel(gtsb_pkg::ModeFill,   32'h00000000, 32'h00000000, 32'h00000000));
    offer_pixel(make_pixel(gtsb_pkg::ModeFill,   32'hffffffff, 32'hffffffff, 32'hffffffff));
    offer_pixel(make_pixel(gtsb_pkg::ModeFill,   32'h20ffc080, 32'h00000000, 32'hffffffff));
    offer_pixel(make_pixel(gtsb_pkg::ModeFill,   32'h80404040, 32'hdeadbeef, 32'h11223344));
    offer_pixel(make_pixel(gtsb_pkg::ModeFill,   32'hff102030, 32'hffffffff, 32'h89abcdef));
    // alpha8: transparent and opaque coverage, mid values
    offer_pixel(make_pixel(gtsb_pkg::ModeAlpha8, 32'hffffffff, 32'h00ffffff, 32'h80808080));
    offer_pixel(make_pixel(gtsb_pkg::ModeAlpha8, 32'hffffffff, 32'hff000000, 32'h00000000));
    offer_pixel(make_pixel(gtsb_pkg::ModeAlpha8, 32'h80ff8000, 32'h80000000, 32'h40404040));
    offer_pixel(make_pixel(gtsb_pkg::ModeAlpha8, 32'h00ffffff, 32'hffffffff, 32'hffffffff));
    // lcd: per-channel coverage, zero coverage, full coverage, zero color alpha
    offer_pixel(make_pixel(gtsb_pkg::ModeLcd,    32'hffffffff, 32'h00ff8000, 32'h20406080));
    offer_pixel(make_pixel(gtsb_pkg::ModeLcd,    32'hffffffff, 32'hff000000, 32'hffffffff));
    offer_pixel(make_pixel(gtsb_pkg::ModeLcd,    32'h80ffffff, 32'h00ffffff, 32'h00000000));
    offer_pixel(make_pixel(gtsb_pkg::ModeLcd,    32'h00ffffff, 32'h00ffffff, 32'h7f7f7f7f));
    offer_pixel(make_pixel(gtsb_pkg::ModeLcd,    32'hffffffff, 32'hffffffff, 32'hffffffff));
    // bgra: color alpha zero and full, texel channels above its alpha
    offer_pixel(make_pixel(gtsb_pkg::ModeBgra,   32'h00ffffff, 32'hffffffff, 32'h12345678));
    offer_pixel(make_pixel(gtsb_pkg::ModeBgra,   32'hff000000, 32'h80ff4020, 32'hffffffff));
    offer_pixel(make_pixel(gtsb_pkg::ModeBgra,   32'hffffffff, 32'h10ffffff, 32'hffffffff));
    offer_pixel(make_pixel(gtsb_pkg::ModeBgra,   32'h00000000, 32'h00000000, 32'h00000000));

    // random pixels with idling on both sides
    for (n = 0; n < RandomHead; n++) offer_pixel(random_pixel());

    // back-to-back stretch with no idling; after forty pixels the receiver holds off
    src_idle_en = 1'b0;
    sink_idle_en <= 1'b0;
    for (n = 0; n < SteadyRun; n++) begin
      if (n == 40) hold_req <= hold_req + 1;
      offer_pixel(random_pixel());
    end
    src_idle_en = 1'b1;
    sink_idle_en <= 1'b1;

    for (n = 0; n < RandomTail; n++) offer_pixel(random_pixel());
    in_valid_i <= 1'b0;

    // drain, bounded by the watchdog
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("shaded %0d pixels over fill, alpha8, lcd and bgra modes with edge bytes,",
             shaded_cnt);
    $display("saturating blends and a %0d-cycle receiver hold-off; %0d results compared",
             HoldOffCycles, checked_cnt);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/gtsb_pkg.sv
src/gtsb_shade.sv
src/gtsb_blend.sv
src/glyph_texel_shade_and_blend.sv
verif/gtsb_pixel_checker.sv
verif/tb_glyph_texel_shade_and_blend.sv
